// ===== rtl/time_of_day_clock_display_unit_defines.svh =====
// assertion macros shared by the time-of-day clock display rtl
`ifndef TIME_OF_DAY_CLOCK_DISPLAY_UNIT_DEFINES_SVH
`define TIME_OF_DAY_CLOCK_DISPLAY_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define TODCD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define TODCD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/todcd_pkg.sv =====
// types, constants and segment tables of the time-of-day clock display
package todcd_pkg;

	// stored count and clamped time of day widths
	localparam int COUNT_W = 19;
	localparam int NOW_W   = 17;
	localparam int NUM_DIGITS = 6;

	localparam logic [COUNT_W-1:0] SECS_PER_DAY  = 19'd86400;
	localparam logic [NOW_W-1:0]   LAST_SEC      = 17'd86399;
	localparam int                 SECS_PER_HOUR = 3600;
	localparam int                 SECS_PER_MIN  = 60;

	// reciprocal multipliers: hour = now*37283 >> 27, minute = rem*2185 >> 17
	localparam logic [15:0] HOUR_RECIP = 16'd37283;
	localparam int          HOUR_SHIFT = 27;
	localparam logic [11:0] MIN_RECIP  = 12'd2185;
	localparam int          MIN_SHIFT  = 17;

	localparam logic [2:0] LAST_POS  = 3'd5;
	localparam logic [2:0] FIRST_ANODE_POS = 3'd4;

	// count after reset: 00:01:00
	localparam logic [COUNT_W-1:0] COUNT_RESET = 19'd60;

	// register map
	localparam logic [0:0] REG_HOUR_MODE = 1'b0;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_TICK = 1'b1
	} todcd_op_t;

	// one tick worth of display digits, position 0 first
	typedef struct packed {
		logic                          pm;
		logic [NUM_DIGITS-1:0][3:0]    digit;
	} todcd_entry_t;

	// common-cathode pattern, bit 0 is segment a, active high
	function automatic logic [7:0] seg_cathode(input logic [3:0] d);
		logic [7:0] p;
		begin
			unique case (d)
				4'd0: p = 8'h3F;
				4'd1: p = 8'h06;
				4'd2: p = 8'h5B;
				4'd3: p = 8'h4F;
				4'd4: p = 8'h66;
				4'd5: p = 8'h6D;
				4'd6: p = 8'h7D;
				4'd7: p = 8'h07;
				4'd8: p = 8'h7F;
				4'd9: p = 8'h6F;
				default: p = 8'h00;
			endcase
			return p;
		end
	endfunction

	// common-anode pattern, active low
	function automatic logic [7:0] seg_anode(input logic [3:0] d);
		logic [7:0] p;
		begin
			unique case (d)
				4'd0: p = 8'hC0;
				4'd1: p = 8'hF9;
				4'd2: p = 8'hA4;
				4'd3: p = 8'hB0;
				4'd4: p = 8'h99;
				4'd5: p = 8'h92;
				4'd6: p = 8'h82;
				4'd7: p = 8'hF8;
				4'd8: p = 8'h80;
				4'd9: p = 8'h90;
				default: p = 8'hFF;
			endcase
			return p;
		end
	endfunction

	// tens digit of a value below 64
	function automatic logic [2:0] tens_of(input logic [5:0] v);
		logic [2:0] t;
		begin
			if (v >= 6'd60)
				t = 3'd6;
			else if (v >= 6'd50)
				t = 3'd5;
			else if (v >= 6'd40)
				t = 3'd4;
			else if (v >= 6'd30)
				t = 3'd3;
			else if (v >= 6'd20)
				t = 3'd2;
			else if (v >= 6'd10)
				t = 3'd1;
			else
				t = 3'd0;
			return t;
		end
	endfunction

endpackage

// ===== rtl/todcd_front.sv =====
// front end: takes beats, holds the seconds count and splits ticks into digits
`include "time_of_day_clock_display_unit_defines.svh"

module todcd_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    hour_mode_24,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    in_op,
	input  logic [7:0]              hours_bcd,
	input  logic [7:0]              minutes_bcd,
	input  logic [7:0]              seconds_bcd,
	output logic                    push,
	output todcd_pkg::todcd_entry_t push_data,
	input  logic                    q_full
);
	import todcd_pkg::*;

	logic [COUNT_W-1:0] count_q;
	logic [NOW_W-1:0]   now_c;
	logic [COUNT_W-1:0] load_count;
	logic [6:0]         h_unit;
	logic [7:0]         m_unit;
	logic [7:0]         s_unit;
	logic               accept;
	logic               tick_acc;
	logic               en;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic [NOW_W-1:0]  now_s1, now_s2;
	logic [4:0]        hour_s2, hour_s3, hour_s4, hour_s5;
	logic [11:0]       rem_s3, rem_s4;
	logic [5:0]        min_s4, min_s5;
	logic [5:0]        sec_s5;
	todcd_entry_t      entry_s6;

	logic [32:0] hour_prod;
	logic [23:0] min_prod;
	logic [4:0]  shown;
	logic [2:0]  ht, mt, st;

	// whole pipeline moves unless the last stage waits on a full queue
	assign en       = !vld_s6 || !q_full;
	assign in_ready = en;
	assign accept   = in_valid && in_ready;
	assign tick_acc = accept && (todcd_op_t'(in_op) == OP_TICK);

	// bcd fields to units, tens nibble weighted by ten
	assign h_unit = 7'(hours_bcd[6:4]) * 7'd10 + 7'(hours_bcd[3:0]);
	assign m_unit = 8'(minutes_bcd[7:4]) * 8'd10 + 8'(minutes_bcd[3:0]);
	assign s_unit = 8'(seconds_bcd[7:4]) * 8'd10 + 8'(seconds_bcd[3:0]);
	assign load_count = 19'(s_unit) + 19'(m_unit) * 19'(SECS_PER_MIN)
		+ 19'(h_unit) * 19'(SECS_PER_HOUR);

	// a count at or past one day reads as midnight
	assign now_c = (count_q >= SECS_PER_DAY) ? '0 : count_q[NOW_W-1:0];

	// seconds-of-day count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= COUNT_RESET;
		end else if (accept) begin
			if (todcd_op_t'(in_op) == OP_LOAD)
				count_q <= load_count;
			else if (now_c == LAST_SEC)
				count_q <= '0;
			else
				count_q <= 19'(now_c) + 19'd1;
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s1 <= tick_acc;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	assign hour_prod = 33'(now_s1) * 33'(HOUR_RECIP);
	assign min_prod  = 24'(rem_s3) * 24'(MIN_RECIP);

	// displayed hour and tens digits
	always_comb begin
		if (hour_mode_24)
			shown = hour_s5;
		else if (hour_s5 >= 5'd12)
			shown = hour_s5 - 5'd12;
		else
			shown = hour_s5;
		ht = tens_of(6'(shown));
		mt = tens_of(min_s5);
		st = tens_of(sec_s5);
	end

	// conversion stages: hour, remainder, minute, second, digits
	always_ff @(posedge clk) begin
		if (en) begin
			now_s1  <= now_c;
			now_s2  <= now_s1;
			hour_s2 <= hour_prod[HOUR_SHIFT +: 5];
			hour_s3 <= hour_s2;
			rem_s3  <= 12'(now_s2 - 17'(hour_s2) * 17'(SECS_PER_HOUR));
			hour_s4 <= hour_s3;
			rem_s4  <= rem_s3;
			min_s4  <= min_prod[MIN_SHIFT +: 6];
			hour_s5 <= hour_s4;
			min_s5  <= min_s4;
			sec_s5  <= 6'(rem_s4 - 12'(min_s4) * 12'(SECS_PER_MIN));
			entry_s6.pm       <= (hour_s5 >= 5'd12);
			entry_s6.digit[0] <= 4'(ht);
			entry_s6.digit[1] <= 4'(6'(shown) - 6'(ht) * 6'd10);
			entry_s6.digit[2] <= 4'(mt);
			entry_s6.digit[3] <= 4'(min_s5 - 6'(mt) * 6'd10);
			entry_s6.digit[4] <= 4'(st);
			entry_s6.digit[5] <= 4'(sec_s5 - 6'(st) * 6'd10);
		end
	end

	assign push      = vld_s6 && !q_full;
	assign push_data = entry_s6;

	// checks
	`TODCD_ASSERT_NEXT(a_count_in_day, tick_acc, count_q < SECS_PER_DAY,
		"count past one day after a tick")
	`TODCD_ASSERT_NOW(a_stall_holds, vld_s6 && q_full, !in_ready,
		"input taken while the pipeline is stalled")

endmodule

// ===== rtl/todcd_queue.sv =====
// short queue of converted digit sets between front and back
`include "time_of_day_clock_display_unit_defines.svh"

module todcd_queue #(
	parameter int DEPTH = 4
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  todcd_pkg::todcd_entry_t push_data,
	output logic                    full,
	input  logic                    pop,
	output todcd_pkg::todcd_entry_t pop_data,
	output logic                    not_empty
);
	import todcd_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	todcd_entry_t     mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full      = (cnt_q == CNT_W'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	// checks
	`TODCD_ASSERT_NOW(a_no_overflow, push, !full, "push into a full queue")
	`TODCD_ASSERT_NOW(a_no_underflow, pop, not_empty, "pop from an empty queue")

endmodule

// ===== rtl/todcd_back.sv =====
// back end: walks the six digit positions of each set and drives result beats
`include "time_of_day_clock_display_unit_defines.svh"

module todcd_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    q_not_empty,
	input  todcd_pkg::todcd_entry_t q_data,
	output logic                    pop,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [2:0]              digit_position,
	output logic [3:0]              digit_value,
	output logic [7:0]              segment_pattern,
	output logic                    pm_flag,
	output logic                    last_digit
);
	import todcd_pkg::*;

	logic         busy_q;
	logic [2:0]   pos_q;
	todcd_entry_t cur_q;
	logic         fire;
	logic         at_last;

	assign fire    = busy_q && out_ready;
	assign at_last = (pos_q == LAST_POS);
	assign pop     = q_not_empty && (!busy_q || (fire && at_last));

	// position sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q  <= '0;
		end else if (pop) begin
			busy_q <= 1'b1;
			pos_q  <= '0;
		end else if (fire) begin
			if (at_last)
				busy_q <= 1'b0;
			else
				pos_q <= pos_q + 3'd1;
		end
	end

	// current digit set
	always_ff @(posedge clk) begin
		if (pop)
			cur_q <= q_data;
	end

	// result beat fields
	assign out_valid      = busy_q;
	assign digit_position = pos_q;
	assign digit_value    = cur_q.digit[pos_q];
	assign pm_flag        = cur_q.pm;
	assign last_digit     = at_last;
	assign segment_pattern = (pos_q < FIRST_ANODE_POS) ? seg_cathode(digit_value)
		: seg_anode(digit_value);

	// checks
	`TODCD_ASSERT_NOW(a_pos_range, busy_q, pos_q <= LAST_POS, "digit position out of range")
	`TODCD_ASSERT_NEXT(a_pos_step, fire && !at_last && !pop,
		busy_q && (pos_q == 3'($past(pos_q) + 3'd1)), "digit position skipped")

endmodule

// ===== rtl/time_of_day_clock_display_unit.sv =====
// top level of the time-of-day clock display: config register, front, queue, back
//
// Keeps a seconds-of-day count (reset 00:01:00). A load beat (tuser 0) sets the
// count from BCD hours, minutes and seconds and yields no result. A tick beat
// (tuser 1) yields six result beats, hour tens to second ones, then advances
// the count by one second, wrapping at midnight. Input beats are taken one per
// cycle while the six-stage conversion pipeline and the QUEUE_DEPTH entry queue
// have room; each tick yields one output beat per digit, and sustained
// throughput is set by the output position sequencer. A tick's first result is
// registered through the conversion stages and the queue before the back end
// drives it. hour_mode_24 at byte address 0 picks 24-hour display; write it
// only while no tick is in flight.
`include "time_of_day_clock_display_unit_defines.svh"

module time_of_day_clock_display_unit #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	// apb configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [0:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // hours_bcd, minutes_bcd, seconds_bcd
	input  logic        s_tuser,   // opcode
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // digit_position, digit_value, segment_pattern, pm_flag
	output logic        m_tlast    // last_digit
);
	import todcd_pkg::*;

	logic         hour_mode_q;
	logic         push;
	logic         pop;
	logic         q_full;
	logic         q_not_empty;
	todcd_entry_t push_data;
	todcd_entry_t pop_data;
	logic [2:0]   digit_position;
	logic [3:0]   digit_value;
	logic [7:0]   segment_pattern;
	logic         pm_flag;
	logic         cfg_write;

	// configuration register
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign prdata    = (paddr == REG_HOUR_MODE) ? {31'd0, hour_mode_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hour_mode_q <= 1'b0;
		end else if (cfg_write && paddr == REG_HOUR_MODE) begin
			hour_mode_q <= pwdata[0];
		end
	end

	todcd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.hour_mode_24 (hour_mode_q),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.in_op        (s_tuser),
		.hours_bcd    (s_tdata[7:0]),
		.minutes_bcd  (s_tdata[15:8]),
		.seconds_bcd  (s_tdata[23:16]),
		.push         (push),
		.push_data    (push_data),
		.q_full       (q_full)
	);

	todcd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.pop_data  (pop_data),
		.not_empty (q_not_empty)
	);

	todcd_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_not_empty     (q_not_empty),
		.q_data          (pop_data),
		.pop             (pop),
		.out_valid       (m_tvalid),
		.out_ready       (m_tready),
		.digit_position  (digit_position),
		.digit_value     (digit_value),
		.segment_pattern (segment_pattern),
		.pm_flag         (pm_flag),
		.last_digit      (m_tlast)
	);

	// pack result beat
	assign m_tdata = {pm_flag, segment_pattern, digit_value, digit_position};

endmodule

// ===== bench/tb_time_of_day_clock_display_unit.sv =====
// testbench for the time-of-day clock display unit: digit predictor and stream checks
`timescale 1ns / 100ps

module tb_time_of_day_clock_display_unit;
	import todcd_pkg::*;

	localparam int CLK_HALF    = 5;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE      = 24;
	localparam int HOLD_CYCLES = 400;
	localparam int HOLD_AFTER  = 60;

	// expected display beat
	typedef struct packed {
		logic [2:0] pos;
		logic [3:0] value;
		logic [7:0] seg;
		logic       pm;
		logic       end_flag;
	} digit_beat_t;

	// predicts the digit beats of each tick and checks them in order
	class clock_digit_scoreboard;
		int unsigned   day_count;
		bit            mode_24;
		digit_beat_t   digits_due[$];
		int            errors;
		int            checked;
		logic [7:0]    cathode_seg[10];
		logic [7:0]    anode_seg[10];

		function new();
			day_count = 60;
			mode_24   = 1'b0;
			errors    = 0;
			checked   = 0;
			cathode_seg = '{8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F};
			anode_seg   = '{8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90};
		endfunction

		task report(input string msg);
			errors++;
			if (errors <= 100)
				$display("[%0t] mismatch: %s", $realtime, msg);
		endtask

		function int pending();
			return digits_due.size();
		endfunction

		function void set_mode(input bit m24);
			mode_24 = m24;
		endfunction

		// load sets the count from bcd bytes, tick queues six digit beats
		function void note_input(input todcd_op_t op, input logic [23:0] data);
			int unsigned now, hr, mn, sc, shown;
			int unsigned digit[6];
			digit_beat_t b;
			if (op == OP_LOAD) begin
				hr = data[6:4] * 10 + data[3:0];
				mn = data[15:12] * 10 + data[11:8];
				sc = data[23:20] * 10 + data[19:16];
				day_count = (sc + 60 * mn + 3600 * hr) & 32'h7FFFF;
			end else begin
				now = (day_count >= 86400) ? 0 : day_count;
				hr = now / 3600;
				mn = (now / 60) % 60;
				sc = now % 60;
				shown = mode_24 ? hr : hr % 12;
				digit = '{shown / 10, shown % 10, mn / 10, mn % 10, sc / 10, sc % 10};
				for (int k = 0; k < 6; k++) begin
					b.pos      = k[2:0];
					b.value    = digit[k][3:0];
					b.seg      = (k < 4) ? cathode_seg[digit[k]] : anode_seg[digit[k]];
					b.pm       = (hr >= 12);
					b.end_flag = (k == 5);
					digits_due.push_back(b);
				end
				now++;
				day_count = (now >= 86400) ? 0 : now;
			end
		endfunction

		// compare one result beat with the oldest expectation
		task check_result(input logic [15:0] data, input logic tlast_bit);
			digit_beat_t e;
			checked++;
			if (digits_due.size() == 0) begin
				report($sformatf("unexpected beat tdata=%h tlast=%b", data, tlast_bit));
			end else begin
				e = digits_due.pop_front();
				if (data[2:0] !== e.pos)
					report($sformatf("position got %0d exp %0d", data[2:0], e.pos));
				if (data[6:3] !== e.value)
					report($sformatf("pos %0d digit got %0d exp %0d", e.pos, data[6:3], e.value));
				if (data[14:7] !== e.seg)
					report($sformatf("pos %0d segments got %h exp %h", e.pos, data[14:7], e.seg));
				if (data[15] !== e.pm)
					report($sformatf("pos %0d pm got %b exp %b", e.pos, data[15], e.pm));
				if (tlast_bit !== e.end_flag)
					report($sformatf("pos %0d tlast got %b exp %b", e.pos, tlast_bit, e.end_flag));
			end
		endtask
	endclass

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [0:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata  = '0;  // hours_bcd, minutes_bcd, seconds_bcd
	logic        s_tuser  = 1'b0; // opcode
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;   // digit_position, digit_value, segment_pattern, pm_flag
	logic        m_tlast;   // last_digit

	clock_digit_scoreboard digit_board = new();
	int  cycles = 0;
	bit  steady = 1'b0;
	bit  held   = 1'b0;

	time_of_day_clock_display_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// clock
	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_time_of_day_clock_display_unit NOT OK");
			$finish;
		end
	end

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// result side: random stalls plus one long hold-off to fill the block
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!held && digit_board.checked >= HOLD_AFTER) begin
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 40)) @(posedge clk);
			gap = pick_gap();
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap - 1) @(posedge clk);
			end
		end
	end

	// result beat checks
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			digit_board.check_result(m_tdata, m_tlast);
	end

	// offer one input beat and wait for it to be taken
	task send_beat(input todcd_op_t op, input logic [23:0] data);
		int gap;
		gap = steady ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= data;
		do
			@(posedge clk);
		while (!s_tready);
		digit_board.note_input(op, data);
	endtask

	task load_time(input logic [7:0] hh, input logic [7:0] mm, input logic [7:0] ss);
		send_beat(OP_LOAD, {ss, mm, hh});
	endtask

	task tick();
		send_beat(OP_TICK, 24'($urandom));
	endtask

	// wait for every expected beat, then let trailing loads finish
	task settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (digit_board.pending() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// apb write then read back of the hour mode register
	task write_mode(input bit m24);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= REG_HOUR_MODE;
		pwdata  <= {31'd0, m24};
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		digit_board.set_mode(m24);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (prdata !== {31'd0, m24})
			digit_board.report($sformatf("hour mode read %h exp %0d", prdata, m24));
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [7:0] to_bcd(input int v);
		return {4'(v / 10), 4'(v % 10)};
	endfunction

	// random sequences: mostly single ticks, some plausible loads followed by ticks, some noise
	task run_random(input int n);
		int sent, r, runs, hr;
		logic [7:0] hb;
		sent = 0;
		while (sent < n) begin
			r = $urandom_range(0, 99);
			steady = ($urandom_range(0, 3) == 0);
			if (r < 25) begin
				case ($urandom_range(0, 3))
					0: hr = 11;
					1: hr = 23;
					2: hr = 12;
					default: hr = $urandom_range(0, 23);
				endcase
				hb = to_bcd(hr);
				load_time({1'($urandom), hb[6:0]},
					to_bcd(($urandom_range(0, 1) != 0) ? 59 : $urandom_range(0, 59)),
					to_bcd($urandom_range(50, 59)));
				runs = $urandom_range(1, 10);
				sent += 1 + runs;
				repeat (runs) tick();
			end else if (r < 35) begin
				load_time(8'($urandom), 8'($urandom), 8'($urandom));
				runs = $urandom_range(0, 3);
				sent += 1 + runs;
				repeat (runs) tick();
			end else begin
				tick();
				sent++;
			end
		end
		steady = 1'b0;
	endtask

	// main sequence
	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// twelve-hour mode from reset: reset count, midnight, noon edge, overflow, wrap
		tick();
		load_time(8'h00, 8'h00, 8'h00);
		tick();
		load_time(8'h11, 8'h59, 8'h59);
		tick();
		tick();
		load_time(8'hFF, 8'hFF, 8'hFF);
		tick();
		tick();
		load_time(8'h23, 8'h59, 8'h59);
		tick();
		tick();
		load_time(8'hA4, 8'h00, 8'h00);
		tick();
		load_time(8'h13, 8'h45, 8'h07);
		tick();
		settle();

		// 24-hour mode: late evening wrap, noon, single digits
		write_mode(1'b1);
		load_time(8'h23, 8'h59, 8'h58);
		tick();
		tick();
		tick();
		load_time(8'h12, 8'h00, 8'h00);
		tick();
		load_time(8'h09, 8'h09, 8'h09);
		tick();
		run_random(100);
		settle();

		// back to twelve-hour mode
		write_mode(1'b0);
		run_random(100);
		settle();

		if (digit_board.pending() != 0)
			digit_board.report($sformatf("%0d beats never arrived", digit_board.pending()));
		if (digit_board.errors == 0)
			$display("tb_time_of_day_clock_display_unit OK");
		else
			$display("tb_time_of_day_clock_display_unit NOT OK");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/todcd_pkg.sv
rtl/todcd_front.sv
rtl/todcd_queue.sv
rtl/todcd_back.sv
rtl/time_of_day_clock_display_unit.sv
bench/tb_time_of_day_clock_display_unit.sv
